FILE: rtl/assert_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int unsigned LinkW = 11;
    localparam logic [LinkW-1:0] Nil = '1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_DOUBLE  = 2'd3
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

FILE: rtl/ffba_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_mem
// Free-list store: link and size per block, one port, registered read.
// ----------------------------------------------------------------------------
module ffba_mem
    import ffba_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [LinkW-1:0] i_wnext,
    input  logic [LinkW-1:0] i_wsize,
    output logic [LinkW-1:0] o_rnext,
    output logic [LinkW-1:0] o_rsize
);

    logic [2*LinkW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= {i_wnext, i_wsize};
        end
        {o_rnext, o_rsize} <= r_mem[i_addr];
    end

endmodule

FILE: rtl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// Address-ordered first-fit allocator with splitting and coalescing.
// ----------------------------------------------------------------------------
// One request at a time: busy rises on start and falls when the strobed
// result is shown, and the next item can be accepted in that same cycle; the
// result cannot be stalled. Every list entry visited takes the single memory
// port through an address and then its registered data. A free also relinks
// the freed extent and merges it with both neighbors, each by reads and
// write-backs. A rejected request holds busy for one cycle. Each memory entry
// holds both the link and the size of an extent, written together by
// read-modify-write.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int unsigned HEAP_BLOCKS  = 1024,
    parameter int unsigned BLOCK_BYTES  = 64,
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [19:0] i_size_bytes,
    input  logic [10:0] i_start_block,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [9:0]  o_granted_block,
    output logic [15:0] o_payload_offset
);

`include "assert_macros.svh"

    localparam int unsigned AW = (HEAP_BLOCKS > 1) ? $clog2(HEAP_BLOCKS) : 1;
    localparam int unsigned HdrBlocks = (HEADER_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int unsigned BShift = $clog2(BLOCK_BYTES);
    localparam logic [LinkW-1:0] HeapSz = LinkW'(HEAP_BLOCKS);
    localparam logic [LinkW-1:0] SplitMin = LinkW'(HdrBlocks + 1);
    localparam logic [21:0] RoundAdd = 22'(HEADER_BYTES + BLOCK_BYTES - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_A_RD, S_A_WT, S_A_CHK, S_A_WCUR, S_A_WNB, S_A_PRD, S_A_PWT,
        S_A_PWR,
        S_F_RD, S_F_WT, S_F_CHK, S_F_WB, S_F_CRD, S_F_CWT, S_F_CWR,
        S_J_RD, S_J_WT, S_J_NRD, S_J_NWT, S_J_WR, S_J_END, S_DONE
    } t_state;

    t_state r_state;
    logic [21:0] r_need;        // blocks, wide enough to compare before truncation
    logic [LinkW-1:0] r_b, r_cur, r_prev, r_after, r_size, r_nb, r_rem;
    logic [LinkW-1:0] r_head, r_jb, r_jnext, r_jsize, r_jnn, r_jns;
    logic        r_joined_b;    // second join (on cur) already started
    logic [LinkW-1:0] r_guard;
    logic        r_init;        // entry 0 not yet written since reset
    logic        r_valid;
    t_status     r_status;
    logic [9:0]  r_gb;
    logic [15:0] r_off;

    logic             m_we;
    logic [AW-1:0]    m_addr;
    logic [LinkW-1:0] m_wnext, m_wsize, m_rnext_raw, m_rsize_raw;
    logic [LinkW-1:0] m_rnext, m_rsize;
    logic [LinkW-1:0] r_raddr;

    ffba_mem #(.DEPTH(HEAP_BLOCKS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wnext(m_wnext),
        .i_wsize(m_wsize),
        .o_rnext(m_rnext_raw),
        .o_rsize(m_rsize_raw)
    );

    // Entry 0 keeps its reset contents until first written; out-of-heap
    // addresses read as an empty link with size zero.
    always_comb begin
        if (r_raddr >= HeapSz) begin
            m_rnext = Nil;
            m_rsize = '0;
        end else if (r_init && r_raddr == '0) begin
            m_rnext = Nil;
            m_rsize = HeapSz;
        end else begin
            m_rnext = m_rnext_raw;
            m_rsize = m_rsize_raw;
        end
    end

    function automatic logic in_heap(input logic [LinkW-1:0] a);
        return a < HeapSz;
    endfunction

    // Memory port control per state.
    logic [LinkW-1:0] n_addr;
    always_comb begin
        m_we    = 1'b0;
        n_addr  = r_cur;
        m_wnext = Nil;
        m_wsize = '0;
        unique case (r_state)
            S_A_RD, S_F_RD: n_addr = r_cur;
            S_A_WCUR: begin
                n_addr = r_cur; m_we = in_heap(r_cur);
                m_wnext = Nil;
                m_wsize = (r_rem > SplitMin) ? r_need[LinkW-1:0] : r_size;
            end
            S_A_WNB: begin
                n_addr = r_nb; m_we = in_heap(r_nb);
                m_wnext = r_after; m_wsize = r_rem;
            end
            S_A_PRD, S_F_CRD: n_addr = (r_state == S_A_PRD) ? r_prev : r_cur;
            S_A_PWR: begin
                n_addr = r_prev; m_we = in_heap(r_prev);
                m_wnext = (r_rem > SplitMin) ? r_nb : r_after; m_wsize = r_jsize;
            end
            S_F_WB: begin
                n_addr = r_b; m_we = 1'b1;
                m_wnext = r_after; m_wsize = r_size;
            end
            S_F_CWR: begin
                n_addr = r_cur; m_we = in_heap(r_cur);
                m_wnext = r_b; m_wsize = r_jsize;
            end
            S_J_RD: n_addr = r_jb;
            S_J_NRD: n_addr = r_jnext;
            S_J_WR: begin
                n_addr = r_jb; m_we = 1'b1;
                m_wnext = r_jnn; m_wsize = r_jsize + r_jns;
            end
            default: n_addr = r_cur;
        endcase
    end
    assign m_addr = n_addr[AW-1:0];

    logic [21:0] n_need;
    assign n_need = (22'(i_size_bytes) + RoundAdd) >> BShift;

    always_ff @(posedge i_clk) begin
        r_raddr <= n_addr;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_init  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DONE);
            if (m_we && n_addr == '0) begin
                r_init <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_need   <= n_need;
                    r_b      <= i_start_block;
                    r_cur    <= (i_req_type == REQ_FREE
                                 && (r_head == Nil || i_start_block < r_head)) ? Nil : r_head;
                    r_after  <= r_head;
                    r_prev   <= Nil;
                    r_guard  <= '0;
                    r_gb     <= '0;
                    r_off    <= '0;
                    r_joined_b <= 1'b0;
                    if (i_req_type == REQ_ALLOC) begin
                        if (i_size_bytes == '0 || r_head == Nil) begin
                            r_status <= ST_NOSPACE; r_state <= S_DONE;
                        end else begin
                            r_status <= ST_OK; r_state <= S_A_RD;
                        end
                    end else if (i_start_block >= HeapSz) begin
                        r_status <= ST_RANGE; r_state <= S_DONE;
                    end else if (r_head == Nil || i_start_block < r_head) begin
                        if (i_start_block == r_head) begin
                            r_status <= ST_DOUBLE; r_state <= S_DONE;
                        end else begin
                            r_status <= ST_OK; r_state <= S_F_CHK;
                        end
                    end else begin
                        r_status <= ST_OK; r_state <= S_F_RD;
                    end
                end
                // ---- allocate walk ----
                S_A_RD: r_state <= S_A_WT;
                S_A_WT: begin
                    if (22'(m_rsize) >= r_need) begin
                        r_size  <= m_rsize;
                        r_after <= m_rnext;
                        r_rem   <= m_rsize - r_need[LinkW-1:0];
                        r_nb    <= r_cur + r_need[LinkW-1:0];
                        r_state <= S_A_CHK;
                    end else if (m_rnext == Nil || r_guard == HeapSz) begin
                        r_status <= ST_NOSPACE; r_state <= S_DONE;
                    end else begin
                        r_prev  <= r_cur; r_cur <= m_rnext;
                        r_guard <= r_guard + 1'b1;
                        r_state <= S_A_RD;
                    end
                end
                S_A_CHK: r_state <= S_A_WCUR;
                S_A_WCUR: r_state <= (r_rem > SplitMin) ? S_A_WNB : S_A_PRD;
                S_A_WNB: r_state <= S_A_PRD;
                S_A_PRD: begin
                    if (r_prev == Nil) begin
                        r_head  <= (r_rem > SplitMin) ? r_nb : r_after;
                        r_state <= S_DONE;
                        r_gb    <= r_cur[9:0];
                        r_off   <= 16'(32'(r_cur) * BLOCK_BYTES + HEADER_BYTES);
                    end else begin
                        r_state <= S_A_PWT;
                    end
                end
                S_A_PWT: begin r_jsize <= m_rsize; r_state <= S_A_PWR; end
                S_A_PWR: begin
                    r_gb    <= r_cur[9:0];
                    r_off   <= 16'(32'(r_cur) * BLOCK_BYTES + HEADER_BYTES);
                    r_state <= S_DONE;
                end
                // ---- free walk ----
                S_F_RD: r_state <= S_F_WT;
                S_F_WT: begin
                    // After the last allowed step the walk stops where it landed.
                    if (m_rnext == Nil || !(r_b > m_rnext) || r_guard == HeapSz + 1'b1) begin
                        r_after <= m_rnext; r_state <= S_F_CHK;
                    end else begin
                        r_cur <= m_rnext; r_guard <= r_guard + 1'b1;
                        r_state <= S_F_RD;
                    end
                end
                S_F_CHK: begin
                    if (r_cur != Nil && (r_b == r_cur || r_b == r_after)) begin
                        r_status <= ST_DOUBLE; r_state <= S_DONE;
                    end else begin
                        r_state <= S_F_CRD; // fetch sizes of cur, then b, via join path
                        r_jb <= r_b;
                    end
                end
                // read cur's size, then b's own size (kept in its entry), before relinking
                S_F_CRD: r_state <= S_F_CWT;
                S_F_CWT: begin
                    r_jsize <= m_rsize;        // size of cur
                    r_state <= S_J_NRD;        // reuse: read b's size
                    r_jnext <= r_b;
                end
                S_J_NRD: r_state <= S_J_NWT;
                S_J_NWT: begin
                    if (r_jb == r_b && r_jnext == r_b) begin
                        // b's size fetched; now write b and cur links
                        r_size  <= m_rsize;
                        r_state <= S_F_WB;
                    end else begin
                        r_jns <= m_rsize; r_jnn <= m_rnext;
                        r_state <= (in_heap(r_jb) && r_jnext != Nil
                                    && {1'b0, r_jb} + {1'b0, r_jsize} == {1'b0, r_jnext})
                                   ? S_J_WR : S_J_END;
                    end
                end
                S_F_WB: begin
                    if (r_cur == Nil) begin
                        r_head <= r_b; r_state <= S_J_RD;
                    end else begin
                        r_state <= S_F_CWR;
                    end
                end
                S_F_CWR: r_state <= S_J_RD;
                // ---- join(r_jb) ----
                S_J_RD: r_state <= S_J_WT;
                S_J_WT: begin
                    r_jnext <= m_rnext; r_jsize <= m_rsize;
                    r_state <= (m_rnext == Nil) ? S_J_END : S_J_NRD;
                end
                S_J_WR: r_state <= S_J_END;
                S_J_END: begin
                    if (!r_joined_b && r_cur != Nil) begin
                        r_joined_b <= 1'b1; r_jb <= r_cur; r_state <= S_J_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_granted_block = r_gb;
    assign o_payload_offset = r_off;

    `ASSERT_NXT(a_done_strobe, i_clk, i_rst_n, r_state == S_DONE, o_valid, "missing strobe")
    `ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy || $past(start), "strobe busy")
    `ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_granted_block == '0 && o_payload_offset == '0, "fail payload")

endmodule
